>>> rtl/terminal_value_set_parser_macros.svh
// Assertion macros shared by the parser modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef TERMINAL_VALUE_SET_PARSER_MACROS_SVH
`define TERMINAL_VALUE_SET_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every edge outside reset.
`define TVSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence checked on the edge that follows the antecedent.
`define TVSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TVSP_ASSERT(lbl, prop, msg)
`define TVSP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/tvsp_pkg.sv
`timescale 1ns / 1ps

package tvsp_pkg;

    // Default sizes.
    localparam int DEF_NUMBER_BUFFER_LEN = 10;
    localparam int DEF_VIEW_SLOTS        = 5;

    // Terminal characters.
    localparam logic [7:0] KEY_ESC   = 8'h1B;
    localparam logic [7:0] KEY_SPACE = 8'h20;
    localparam logic [7:0] KEY_ENTER = 8'h0D;
    localparam logic [7:0] KEY_MINUS = 8'h2D;
    localparam logic [7:0] KEY_0     = 8'h30;
    localparam logic [7:0] KEY_9     = 8'h39;
    localparam logic [7:0] KEY_Q     = 8'h71;
    localparam logic [7:0] KEY_W     = 8'h77;
    localparam logic [7:0] KEY_E     = 8'h65;
    localparam logic [7:0] KEY_R     = 8'h72;

    // Buffer entries hold a 4-bit code: 0 to 9 for digits, plus these two.
    localparam logic [3:0] CODE_MINUS = 4'hA;
    localparam logic [3:0] CODE_EMPTY = 4'hF;

    // Saturation limits of the magnitude.
    localparam logic [35:0] LIMIT_POS = 36'h0_7FFF_FFFF;
    localparam logic [35:0] LIMIT_NEG = 36'h0_8000_0000;

    // Status of the serial converter as seen by the control.
    typedef struct packed {
        logic               busy;
        logic signed [31:0] value;
    } tvsp_conv_stat_t;

endpackage

>>> rtl/tvsp_if.sv
`timescale 1ns / 1ps

// Channel carrying received terminal bytes.
interface tvsp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// Channel carrying one result item per received byte.
interface tvsp_res_if;
    logic               valid;
    logic               ready;
    logic               echo_valid;
    logic [7:0]         echo_byte;
    logic               write_valid;
    logic [2:0]         write_index;
    logic signed [31:0] write_value;
    logic               refresh_request;

    modport source (
        output valid, output echo_valid, output echo_byte, output write_valid,
        output write_index, output write_value, output refresh_request,
        input ready
    );
    modport sink (
        input valid, input echo_valid, input echo_byte, input write_valid,
        input write_index, input write_value, input refresh_request,
        output ready
    );
endinterface

>>> rtl/tvsp_nbuf.sv
`timescale 1ns / 1ps

module tvsp_nbuf
    import tvsp_pkg::*;
#(
    parameter int  LEN   = DEF_NUMBER_BUFFER_LEN,
    localparam int IDX_W = $clog2(LEN)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [3:0]       wr_code,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [3:0]       rd_code
);

    logic [3:0] entry_reg [LEN];

    // Ring of character codes; a clear empties every entry at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEN; i++)
            begin
                entry_reg[i] <= CODE_EMPTY;
            end
        end
        else if (clear)
        begin
            for (int i = 0; i < LEN; i++)
            begin
                entry_reg[i] <= CODE_EMPTY;
            end
        end
        else if (wr_en)
        begin
            entry_reg[wr_idx] <= wr_code;
        end
    end

    // Single read port for the converter.
    assign rd_code = entry_reg[rd_idx];

endmodule

>>> rtl/tvsp_conv.sv
`timescale 1ns / 1ps

`include "terminal_value_set_parser_macros.svh"

module tvsp_conv
    import tvsp_pkg::*;
#(
    parameter int  LEN   = DEF_NUMBER_BUFFER_LEN,
    localparam int IDX_W = $clog2(LEN)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic [IDX_W-1:0] rd_idx,
    input  logic [3:0]       rd_code,
    output tvsp_conv_stat_t  stat
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LEN - 1);

    logic             busy_reg, busy_next;
    logic             neg_reg, neg_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      mag_reg, mag_next;
    logic [35:0]      mag_ext;
    logic [35:0]      sum;
    logic [35:0]      limit;
    logic             is_digit;

    // One buffer entry per cycle: times ten by shift and add, plus digit, clamp.
    assign mag_ext  = 36'(mag_reg);
    assign sum      = (mag_ext << 3) + (mag_ext << 1) + 36'(rd_code);
    assign limit    = neg_reg ? LIMIT_NEG : LIMIT_POS;
    assign is_digit = rd_code < 4'd10;

    // Walk of the buffer from entry 0.
    always_comb
    begin
        busy_next = busy_reg;
        neg_next  = neg_reg;
        idx_next  = idx_reg;
        mag_next  = mag_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = 1'b0;
            idx_next  = '0;
            mag_next  = '0;
        end
        else if (busy_reg)
        begin
            if (idx_reg == '0 && rd_code == CODE_MINUS)
            begin
                neg_next = 1'b1;
                idx_next = IDX_W'(1);
            end
            else if (is_digit)
            begin
                mag_next = (sum > limit) ? limit[31:0] : sum[31:0];
                if (idx_reg == IDX_LAST)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            neg_reg  <= 1'b0;
            idx_reg  <= '0;
            mag_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            neg_reg  <= neg_next;
            idx_reg  <= idx_next;
            mag_reg  <= mag_next;
        end
    end

    assign rd_idx     = idx_reg;
    assign stat.busy  = busy_reg;
    assign stat.value = neg_reg ? (32'sd0 - $signed(mag_reg)) : $signed(mag_reg);

    // The magnitude never passes the negative limit.
    `TVSP_ASSERT(a_mag_bound, 36'(mag_reg) <= LIMIT_NEG, "magnitude beyond limit")
    // A positive result never passes the positive limit.
    `TVSP_ASSERT(a_pos_bound, neg_reg || 36'(mag_reg) <= LIMIT_POS, "positive overflow")
    // A start always leaves the walk at entry 0 with a cleared magnitude.
    `TVSP_ASSERT_NEXT(a_start, start, busy_reg && idx_reg == '0 && mag_reg == '0,
        "start did not restart the walk")

endmodule

>>> rtl/terminal_value_set_parser.sv
`timescale 1ns / 1ps

// Channel | Dir | Payload
// rx      | in  | rx_byte
// res     | out | echo_valid, echo_byte, write_valid, write_index, write_value,
//         |     | refresh_request
//
// Each received byte gives one result item, held in an output register.
// A byte other than a command-ending Enter has its result visible in the cycle
// after it is taken. Enter walks the number buffer through the serial
// converter, one entry per cycle, and the result is loaded once the output
// register is free. The reset clears all parser state and empties the
// buffer. A result not yet taken holds off the next byte, unless it is
// taken in the same cycle.
`include "terminal_value_set_parser_macros.svh"

module terminal_value_set_parser
    import tvsp_pkg::*;
#(
    parameter int  NUMBER_BUFFER_LEN = DEF_NUMBER_BUFFER_LEN,
    parameter int  VIEW_SLOTS        = DEF_VIEW_SLOTS,
    localparam int IDX_W             = $clog2(NUMBER_BUFFER_LEN)
)
(
    input  logic              clk,
    input  logic              rst_n,
    tvsp_rx_if.sink           rx,
    tvsp_res_if.source        res
);

    localparam logic [7:0]       SLOT_LAST = 8'(KEY_0 + VIEW_SLOTS - 1);
    localparam logic [IDX_W-1:0] CNT_LAST  = IDX_W'(NUMBER_BUFFER_LEN - 1);

    // Control states.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CONV = 1'b1;

    // Parse phases.
    localparam logic [1:0] PH_INDEX  = 2'd0;
    localparam logic [1:0] PH_SPACE  = 2'd1;
    localparam logic [1:0] PH_NUMBER = 2'd2;

    logic             st_reg, st_next;
    logic [1:0]       phase_reg, phase_next;
    logic [2:0]       target_reg, target_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    logic               res_valid_reg, res_valid_next;
    logic               echo_valid_reg, echo_valid_next;
    logic [7:0]         echo_byte_reg, echo_byte_next;
    logic               write_valid_reg, write_valid_next;
    logic [2:0]         write_index_reg, write_index_next;
    logic signed [31:0] write_value_reg, write_value_next;
    logic               refresh_reg, refresh_next;

    logic [7:0]       c;
    logic             out_free;
    logic             in_fire;
    logic             conv_start;
    logic             conv_load;
    logic             is_digit, is_minus, is_space, is_esc, is_letter, is_slot;
    logic             buf_clear, buf_wr;
    logic [3:0]       buf_code;
    logic [IDX_W-1:0] rd_idx;
    logic [3:0]       rd_code;
    tvsp_conv_stat_t  conv_stat;

    // Handshake.
    assign out_free  = !res_valid_reg || res.ready;
    assign rx.ready  = (st_reg == ST_IDLE) && out_free;
    assign in_fire   = rx.valid && rx.ready;
    assign conv_load = (st_reg == ST_CONV) && !conv_stat.busy && out_free;

    // Byte classes.
    assign c         = rx.rx_byte;
    assign is_digit  = (c >= KEY_0) && (c <= KEY_9);
    assign is_minus  = c == KEY_MINUS;
    assign is_space  = c == KEY_SPACE;
    assign is_esc    = c == KEY_ESC;
    assign is_letter = (c == KEY_Q) || (c == KEY_W) || (c == KEY_E) || (c == KEY_R);
    assign is_slot   = (c >= KEY_0) && (c <= SLOT_LAST);
    assign buf_code  = is_minus ? CODE_MINUS : c[3:0];

    // Parser next state and the immediate part of the result.
    always_comb
    begin
        phase_next  = phase_reg;
        target_next = target_reg;
        cnt_next    = cnt_reg;
        conv_start  = 1'b0;
        buf_wr      = 1'b0;
        buf_clear   = 1'b0;
        refresh_next = 1'b0;
        if (in_fire)
        begin
            if (is_esc)
            begin
                refresh_next = 1'b1;
                buf_clear    = 1'b1;
                cnt_next     = '0;
                phase_next   = PH_INDEX;
                target_next  = '0;
            end
            else if (is_letter)
            begin
                refresh_next = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_INDEX:
                    begin
                        if (is_slot)
                        begin
                            cnt_next    = '0;
                            target_next = c[2:0];
                            phase_next  = PH_SPACE;
                        end
                    end
                    PH_SPACE:
                    begin
                        phase_next = is_space ? PH_NUMBER : PH_INDEX;
                    end
                    PH_NUMBER:
                    begin
                        if (is_digit || is_minus)
                        begin
                            buf_wr   = 1'b1;
                            cnt_next = (cnt_reg == CNT_LAST) ? '0 : cnt_reg + IDX_W'(1);
                        end
                        else if (c == KEY_ENTER && cnt_reg != '0)
                        begin
                            conv_start = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
        if (conv_load)
        begin
            buf_clear  = 1'b1;
            cnt_next   = '0;
            phase_next = PH_INDEX;
        end
    end

    // Control state.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (conv_start)
                begin
                    st_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_load)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Output register loading.
    always_comb
    begin
        res_valid_next   = res_valid_reg && !res.ready;
        echo_valid_next  = echo_valid_reg;
        echo_byte_next   = echo_byte_reg;
        write_valid_next = write_valid_reg;
        write_index_next = write_index_reg;
        write_value_next = write_value_reg;
        if (in_fire && !conv_start)
        begin
            res_valid_next   = 1'b1;
            echo_valid_next  = is_digit || is_minus || is_space;
            echo_byte_next   = (is_digit || is_minus || is_space) ? c : 8'h00;
            write_valid_next = 1'b0;
            write_index_next = '0;
            write_value_next = '0;
        end
        else if (conv_load)
        begin
            res_valid_next   = 1'b1;
            echo_valid_next  = 1'b0;
            echo_byte_next   = 8'h00;
            write_valid_next = 1'b1;
            write_index_next = target_reg;
            write_value_next = conv_stat.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            phase_reg     <= PH_INDEX;
            target_reg    <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            phase_reg     <= phase_next;
            target_reg    <= target_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        echo_valid_reg  <= echo_valid_next;
        echo_byte_reg   <= echo_byte_next;
        write_valid_reg <= write_valid_next;
        write_index_reg <= write_index_next;
        write_value_reg <= write_value_next;
        if ((in_fire && !conv_start) || conv_load)
        begin
            refresh_reg <= refresh_next || conv_load;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.echo_valid      = echo_valid_reg;
    assign res.echo_byte       = echo_byte_reg;
    assign res.write_valid     = write_valid_reg;
    assign res.write_index     = write_index_reg;
    assign res.write_value     = write_value_reg;
    assign res.refresh_request = refresh_reg;

    // Number buffer.
    tvsp_nbuf #(
        .LEN (NUMBER_BUFFER_LEN)
    ) u_nbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (buf_clear),
        .wr_en   (buf_wr),
        .wr_idx  (cnt_reg),
        .wr_code (buf_code),
        .rd_idx  (rd_idx),
        .rd_code (rd_code)
    );

    // Serial decimal converter.
    tvsp_conv #(
        .LEN (NUMBER_BUFFER_LEN)
    ) u_conv (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (conv_start),
        .rd_idx  (rd_idx),
        .rd_code (rd_code),
        .stat    (conv_stat)
    );

    // A write result always carries a refresh and no echo.
    `TVSP_ASSERT(a_write_flags, !(res.valid && res.write_valid) ||
        (res.refresh_request && !res.echo_valid), "write result flags wrong")
    // A started conversion keeps the converter busy on the next edge.
    `TVSP_ASSERT_NEXT(a_conv_busy, conv_start, conv_stat.busy && st_reg == ST_CONV,
        "conversion did not start")
    // Loading a write leaves the parser waiting for a slot with an empty count.
    `TVSP_ASSERT_NEXT(a_after_write, conv_load, phase_reg == PH_INDEX && cnt_reg == '0,
        "parser not reset after write")
    // No byte is taken while a conversion runs.
    `TVSP_ASSERT(a_no_take_conv, !(st_reg == ST_CONV && rx.ready), "byte taken mid conversion")

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import tvsp_pkg::*;

    localparam int NUM_LEN    = DEF_NUMBER_BUFFER_LEN;
    localparam int SLOTS      = DEF_VIEW_SLOTS;
    localparam int ITEM_COUNT = 650;
    localparam int LONG_HOLD  = 400;
    localparam int STALL_MAX  = 3000;

    // Parser phases as the command is typed in.
    typedef enum logic [1:0] {
        PH_SLOT   = 2'd0,
        PH_SPACE  = 2'd1,
        PH_NUMBER = 2'd2,
        PH_SPARE  = 2'd3
    } parse_phase_t;

    typedef struct packed {
        logic               echo_valid;
        logic [7:0]         echo_byte;
        logic               write_valid;
        logic [2:0]         write_index;
        logic signed [31:0] write_value;
        logic               refresh_request;
    } parse_result_t;

    // Tracks the parser state, predicts one result per byte and checks results in order.
    class value_set_scoreboard;
        parse_phase_t  phase;
        logic [2:0]    slot;
        logic [7:0]    chars [NUM_LEN];
        int unsigned   wr_pos;
        parse_result_t pending_results [$];
        int            errors;

        function new();
            phase  = PH_SLOT;
            slot   = '0;
            errors = 0;
            clear_number();
        endfunction

        static function bit is_digit(logic [7:0] c);
            return c >= KEY_0 && c <= KEY_9;
        endfunction

        function void clear_number();
            foreach (chars[i])
                chars[i] = '0;
            wr_pos = 0;
        endfunction

        // Reads the buffer like atoi from entry 0 and saturates to 32 bits.
        function logic [31:0] number_value();
            logic [35:0] mag;
            logic [35:0] lim;
            bit          neg;
            int          i;
            mag = '0;
            neg = (chars[0] == KEY_MINUS);
            lim = neg ? LIMIT_NEG : LIMIT_POS;
            for (i = neg ? 1 : 0; i < NUM_LEN; i++)
            begin
                if (!is_digit(chars[i]))
                    break;
                mag = mag * 10 + 36'(chars[i] - KEY_0);
                if (mag > lim)
                    mag = lim;
            end
            return neg ? -mag[31:0] : mag[31:0];
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Called for every accepted byte.
        function void note_byte(logic [7:0] b);
            parse_result_t r;
            r = '0;
            if (b == KEY_ESC)
            begin
                r.refresh_request = 1'b1;
                clear_number();
                phase = PH_SLOT;
                slot  = '0;
            end
            else if (b == KEY_Q || b == KEY_W || b == KEY_E || b == KEY_R)
            begin
                r.refresh_request = 1'b1;
            end
            else
            begin
                case (phase)
                    PH_SLOT:
                    begin
                        if (b >= KEY_0 && b < KEY_0 + SLOTS)
                        begin
                            wr_pos = 0;
                            slot   = 3'(b - KEY_0);
                            phase  = PH_SPACE;
                        end
                    end
                    PH_SPACE:
                    begin
                        phase = (b == KEY_SPACE) ? PH_NUMBER : PH_SLOT;
                    end
                    PH_NUMBER:
                    begin
                        if (is_digit(b) || b == KEY_MINUS)
                        begin
                            chars[wr_pos] = b;
                            wr_pos = (wr_pos + 1) % NUM_LEN;
                        end
                        else if (b == KEY_ENTER && wr_pos != 0)
                        begin
                            r.write_valid     = 1'b1;
                            r.write_index     = slot;
                            r.write_value     = number_value();
                            r.refresh_request = 1'b1;
                            clear_number();
                            phase = PH_SLOT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (is_digit(b) || b == KEY_MINUS || b == KEY_SPACE)
            begin
                r.echo_valid = 1'b1;
                r.echo_byte  = b;
            end
            pending_results.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected 0x%h actual 0x%h", $time, field, want, got);
                errors++;
            end
        endfunction

        // Called for every accepted result item.
        function void check_result(parse_result_t got);
            parse_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %p", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("echo_valid", 32'(want.echo_valid), 32'(got.echo_valid));
            compare_field("echo_byte", 32'(want.echo_byte), 32'(got.echo_byte));
            compare_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
            compare_field("write_index", 32'(want.write_index), 32'(got.write_index));
            compare_field("write_value", want.write_value, got.write_value);
            compare_field("refresh_request", 32'(want.refresh_request),
                          32'(got.refresh_request));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tvsp_rx_if  rx_ch ();
    tvsp_res_if res_ch ();

    terminal_value_set_parser #(
        .NUMBER_BUFFER_LEN (NUM_LEN),
        .VIEW_SLOTS        (SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch.sink),
        .res   (res_ch.source)
    );

    value_set_scoreboard sb;
    bit                  idle_on;
    int                  gap_odds;
    int                  items_sent;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offers one byte, maybe after an idle burst, and waits until it is taken.
    task automatic send_byte(input logic [7:0] b, input bit counted = 1'b1);
        if (idle_on && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        sb.note_byte(b);
        if (counted)
            items_sent++;
    endtask

    task automatic send_chars(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_command(input int slot_num, input string s);
        send_byte(KEY_0 + 8'(slot_num));
        send_byte(KEY_SPACE);
        send_chars(s);
        send_byte(KEY_ENTER);
    endtask

    function automatic logic [7:0] control_key();
        case ($urandom_range(0, 4))
            0: return KEY_ESC;
            1: return KEY_Q;
            2: return KEY_W;
            3: return KEY_E;
            default: return KEY_R;
        endcase
    endfunction

    // A command with random content; a few of them are broken on purpose.
    task automatic send_random_command();
        int         variant;
        int         n_chars;
        logic [7:0] c;
        variant  = $urandom_range(0, 19);
        gap_odds = $urandom_range(0, 4);
        if (variant == 0)
            send_byte(KEY_0 + 8'($urandom_range(SLOTS, 9)));
        else
            send_byte(KEY_0 + 8'($urandom_range(0, SLOTS - 1)));
        if (variant == 1)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        else
            send_byte(KEY_SPACE);
        if (variant == 2)
            n_chars = 0;
        else if ($urandom_range(0, 5) == 0)
            n_chars = $urandom_range(NUM_LEN - 1, NUM_LEN + 4);
        else
            n_chars = $urandom_range(1, NUM_LEN - 2);
        for (int i = 0; i < n_chars; i++)
        begin
            case ($urandom_range(0, 29))
                0: c = KEY_MINUS;
                1: c = control_key();
                2: c = 8'($urandom_range(0, 255));
                default: c = KEY_0 + 8'($urandom_range(0, 9));
            endcase
            if (i == 0 && $urandom_range(0, 2) == 0)
                c = KEY_MINUS;
            send_byte(c);
        end
        if (variant == 3)
            send_byte(KEY_ESC);
        send_byte(KEY_ENTER);
    endtask

    // Stimulus and end of run.
    initial
    begin : stimulus
        int pick;
        sb            = new();
        idle_on       = 1'b1;
        gap_odds      = 3;
        items_sent    = 0;
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of the byte and a slot digit out of range, all ignored while idle.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(KEY_0 + 8'(SLOTS));
        // Control letters.
        send_byte(KEY_ESC);
        send_byte(KEY_Q);
        send_byte(KEY_W);
        send_byte(KEY_E);
        send_byte(KEY_R);
        // Slot without its space.
        send_byte(KEY_0 + 8'(SLOTS - 1));
        send_byte(8'h78);
        // Other bytes and an empty Enter are ignored; a control letter mid-number.
        send_byte(KEY_0);
        send_byte(KEY_SPACE);
        send_byte(8'h61);
        send_byte(KEY_ENTER);
        send_byte(KEY_Q);
        // A lone minus gives zero.
        send_byte(KEY_MINUS);
        send_byte(KEY_ENTER);
        // A minus after the first character stops the digits.
        send_command(2, "12-3");
        // Exactly a full buffer wraps the count, so Enter is ignored; the next
        // digit overwrites entry 0 and the whole buffer saturates.
        send_byte(KEY_0 + 8'(SLOTS - 1));
        send_byte(KEY_SPACE);
        send_chars("2147483647");
        send_byte(KEY_ENTER);
        send_chars("8");
        send_byte(KEY_ENTER);
        send_command(3, "-12345678");
        // ESC in the middle of a command drops it.
        send_byte(KEY_0 + 8'd1);
        send_byte(KEY_SPACE);
        send_byte(KEY_0 + 8'd7);
        send_byte(KEY_ESC);
        send_byte(KEY_ENTER);

        // Random part: mostly commands, some control letters and noise.
        while (items_sent < ITEM_COUNT)
        begin
            if (items_sent >= ITEM_COUNT - 100)
                idle_on = 1'b0;
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                send_random_command();
            end
            else if (pick == 7)
            begin
                send_byte(control_key());
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        rx_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (NUM_LEN + 8) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result side: takes items with random stalls and one long hold-off.
    initial
    begin : result_sink
        int            hold;
        bit            long_done;
        parse_result_t got;
        hold         = 0;
        long_done    = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got.echo_valid      = res_ch.echo_valid;
                got.echo_byte       = res_ch.echo_byte;
                got.write_valid     = res_ch.write_valid;
                got.write_index     = res_ch.write_index;
                got.write_value     = res_ch.write_value;
                got.refresh_request = res_ch.refresh_request;
                sb.check_result(got);
            end
            if (hold == 0 && !long_done && items_sent >= 250)
            begin
                hold      = LONG_HOLD;
                long_done = 1'b1;
            end
            else if (hold == 0 && idle_on && $urandom_range(0, 9) == 0)
            begin
                hold = $urandom_range(1, 7);
            end
            if (hold != 0)
            begin
                hold--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_MAX)
            begin
                $display("%0t: no progress for %0d cycles", $time, quiet);
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
